// ===== rtl/lpd_pkg.sv =====
// Types and constants shared by the length-prefix deframer modules.
package lpd_pkg;

    localparam int unsigned PREFIX_W = 3;
    localparam logic [PREFIX_W-1:0] PREFIX_RESET = 3'd4;
    localparam logic [PREFIX_W-1:0] MAX_PREFIX_BYTES = 3'd4;
    localparam logic [PREFIX_W-1:0] PREFIX_PASSTHROUGH = 3'd0;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       chunk_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        first_of_message;
        logic        last_of_message;
        logic        empty_message;
        logic [31:0] message_length;
    } t_out_item;

endpackage

// ===== rtl/lpd_framer.sv =====
// Framing state and per-byte decode of the length-prefix deframer.
module lpd_framer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clear,
    input  logic                          i_step,
    input  logic [lpd_pkg::PREFIX_W-1:0]  i_prefix,
    input  lpd_pkg::t_in_item             i_item,
    output logic                          o_res_valid,
    output lpd_pkg::t_out_item            o_res
);

    logic                         r_in_payload;
    logic [lpd_pkg::PREFIX_W-1:0] r_prefix_count;
    logic [31:0]                  r_len_acc;
    logic [31:0]                  r_remaining;
    logic                         r_at_start;

    logic                         n_in_payload;
    logic [lpd_pkg::PREFIX_W-1:0] n_prefix_count;
    logic [31:0]                  n_len_acc;
    logic [31:0]                  n_remaining;
    logic                         n_at_start;

    logic [31:0] shifted_byte;
    logic        last_payload;

    assign shifted_byte = {24'd0, i_item.data_byte} << {r_prefix_count[1:0], 3'b000};
    assign last_payload = (r_remaining <= 32'd1);

    always_comb begin
        n_in_payload   = r_in_payload;
        n_prefix_count = r_prefix_count;
        n_len_acc      = r_len_acc;
        n_remaining    = r_remaining;
        n_at_start     = r_at_start;
        o_res_valid    = 1'b0;
        o_res          = '0;
        if (i_prefix == lpd_pkg::PREFIX_PASSTHROUGH) begin
            o_res_valid            = 1'b1;
            o_res.payload_byte     = i_item.data_byte;
            o_res.first_of_message = r_at_start;
            o_res.last_of_message  = i_item.chunk_end;
            n_at_start             = i_item.chunk_end;
        end else if (!r_in_payload) begin
            n_len_acc      = r_len_acc | shifted_byte;
            n_prefix_count = r_prefix_count + 3'd1;
            if (n_prefix_count >= i_prefix) begin
                if (n_len_acc == 32'd0) begin
                    // An empty message gives a single marked result.
                    o_res_valid            = 1'b1;
                    o_res.first_of_message = 1'b1;
                    o_res.last_of_message  = 1'b1;
                    o_res.empty_message    = 1'b1;
                    n_in_payload           = 1'b0;
                    n_prefix_count         = '0;
                    n_len_acc              = '0;
                    n_remaining            = '0;
                    n_at_start             = 1'b1;
                end else begin
                    n_in_payload = 1'b1;
                    n_remaining  = n_len_acc;
                    n_at_start   = 1'b1;
                end
            end
        end else begin
            o_res_valid            = 1'b1;
            o_res.payload_byte     = i_item.data_byte;
            o_res.first_of_message = r_at_start;
            o_res.last_of_message  = last_payload;
            o_res.message_length   = r_len_acc;
            n_at_start             = 1'b0;
            if (last_payload) begin
                n_in_payload   = 1'b0;
                n_prefix_count = '0;
                n_len_acc      = '0;
                n_remaining    = '0;
                n_at_start     = 1'b1;
            end else begin
                n_remaining = r_remaining - 32'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_in_payload   <= 1'b0;
            r_prefix_count <= '0;
            r_len_acc      <= '0;
            r_remaining    <= '0;
            r_at_start     <= 1'b1;
        end else if (i_step) begin
            r_in_payload   <= n_in_payload;
            r_prefix_count <= n_prefix_count;
            r_len_acc      <= n_len_acc;
            r_remaining    <= n_remaining;
            r_at_start     <= n_at_start;
        end
    end

endmodule

// ===== rtl/length_prefix_deframer_unit.sv =====
// Top level of the length-prefix deframer: handshakes, prefix register, result register.
// Each accepted byte is decoded in the cycle it is taken; its result shows in the next cycle.
// Throughput is one item per cycle while the output side does not stall a held result.
// The input stalls only while a result is held and the output side stalls.
// Synchronous active-low reset sets the prefix size to four and clears the framing state.
// A prefix-size write also clears the framing state.
module length_prefix_deframer_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lpd_pkg::PREFIX_W-1:0]  i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  lpd_pkg::t_in_item             i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output lpd_pkg::t_out_item            o_out
);

    logic [lpd_pkg::PREFIX_W-1:0] r_prefix_bytes;
    logic                         r_out_valid;
    lpd_pkg::t_out_item           r_out;

    logic                         cfg_write;
    logic                         in_accept;
    logic [lpd_pkg::PREFIX_W-1:0] eff_prefix;
    logic                         res_valid;
    lpd_pkg::t_out_item           res;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign eff_prefix  = (r_prefix_bytes > lpd_pkg::MAX_PREFIX_BYTES) ?
                         lpd_pkg::MAX_PREFIX_BYTES : r_prefix_bytes;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    lpd_framer u_framer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (cfg_write),
        .i_step      (in_accept),
        .i_prefix    (eff_prefix),
        .i_item      (i_in),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix_bytes <= lpd_pkg::PREFIX_RESET;
        end else if (cfg_write) begin
            r_prefix_bytes <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= res_valid;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && res_valid) begin
            r_out <= res;
        end
    end

endmodule

// ===== tb/sv/length_prefix_deframer_checker.sv =====
// Checker for the length-prefix deframer: watches all channels, predicts results, compares them.
`timescale 1ns / 1ps

module length_prefix_deframer_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    input  logic                         i_cfg_ready,
    input  logic [lpd_pkg::PREFIX_W-1:0] i_cfg_data,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  lpd_pkg::t_in_item            i_in,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  lpd_pkg::t_out_item           i_out,
    output int                           o_fail_count,
    output int                           o_pending
);

    logic [lpd_pkg::PREFIX_W-1:0] prefix_size;
    logic                         in_payload;
    logic [2:0]                   prefix_seen;
    logic [31:0]                  declared_len;
    logic [31:0]                  bytes_left;
    logic                         msg_start;
    lpd_pkg::t_out_item           deframed_q[$];

    function automatic void clear_framing();
        in_payload = 1'b0;
        prefix_seen = 3'd0;
        declared_len = 32'd0;
        bytes_left = 32'd0;
        msg_start = 1'b1;
    endfunction

    function automatic bit deframe_byte(input lpd_pkg::t_in_item item,
                                        output lpd_pkg::t_out_item res);
        logic [lpd_pkg::PREFIX_W-1:0] eff;
        logic                         last;
        eff = (prefix_size > lpd_pkg::MAX_PREFIX_BYTES) ?
              lpd_pkg::MAX_PREFIX_BYTES : prefix_size;
        res = '0;
        if (eff == lpd_pkg::PREFIX_PASSTHROUGH) begin
            res.payload_byte = item.data_byte;
            res.first_of_message = msg_start;
            res.last_of_message = item.chunk_end;
            msg_start = item.chunk_end;
            return 1'b1;
        end
        if (!in_payload) begin
            declared_len = declared_len | (32'(item.data_byte) << (8 * prefix_seen[1:0]));
            prefix_seen = prefix_seen + 3'd1;
            if (prefix_seen >= eff) begin
                if (declared_len == 32'd0) begin
                    res.first_of_message = 1'b1;
                    res.last_of_message = 1'b1;
                    res.empty_message = 1'b1;
                    clear_framing();
                    return 1'b1;
                end
                in_payload = 1'b1;
                bytes_left = declared_len;
                msg_start = 1'b1;
            end
            return 1'b0;
        end
        last = (bytes_left <= 32'd1);
        res.payload_byte = item.data_byte;
        res.first_of_message = msg_start;
        res.last_of_message = last;
        res.message_length = declared_len;
        msg_start = 1'b0;
        if (last) begin
            clear_framing();
        end else begin
            bytes_left = bytes_left - 32'd1;
        end
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
        if (exp !== act) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
            o_fail_count = o_fail_count + 1;
        end
    endtask

    always @(posedge i_clk) begin
        lpd_pkg::t_out_item res;
        lpd_pkg::t_out_item exp;
        if (!i_rst_n) begin
            prefix_size = lpd_pkg::PREFIX_RESET;
            clear_framing();
            deframed_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                prefix_size = i_cfg_data;
                clear_framing();
            end
            if (i_in_valid && !i_in_stall) begin
                if (deframe_byte(i_in, res)) begin
                    deframed_q.push_back(res);
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (deframed_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, i_out);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    exp = deframed_q.pop_front();
                    check_field("payload_byte", 32'(exp.payload_byte), 32'(i_out.payload_byte));
                    check_field("first_of_message", 32'(exp.first_of_message),
                                32'(i_out.first_of_message));
                    check_field("last_of_message", 32'(exp.last_of_message),
                                32'(i_out.last_of_message));
                    check_field("empty_message", 32'(exp.empty_message),
                                32'(i_out.empty_message));
                    check_field("message_length", exp.message_length, i_out.message_length);
                end
            end
        end
        o_pending = deframed_q.size();
    end

endmodule

// ===== tb/sv/length_prefix_deframer_unit_tb.sv =====
// Testbench top for the length-prefix deframer: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 1ps

module length_prefix_deframer_unit_tb;

    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASE_ITEMS = 70;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [lpd_pkg::PREFIX_W-1:0] cfg_data = lpd_pkg::PREFIX_RESET;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    lpd_pkg::t_in_item            in_item = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    lpd_pkg::t_out_item           out_item;

    int    fail_count;
    int    pending;
    int    cycle_count = 0;
    int    burst_left = 0;
    int    items_sent = 0;
    bit    steady_input = 1'b0;
    bit    hold_req = 1'b0;

    length_prefix_deframer_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item)
    );

    length_prefix_deframer_checker checker_inst (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in         (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out        (out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int mode;
        int phase_left;
        mode = 0;
        phase_left = 0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                out_stall = 1'b1;
                repeat (60) @(negedge clk);
                hold_req = 1'b0;
            end else begin
                if (phase_left == 0) begin
                    phase_left = $urandom_range(20, 80);
                    mode = $urandom_range(0, 3);
                end
                phase_left--;
                case (mode)
                    0: begin
                        out_stall = 1'b0;
                    end
                    1: begin
                        out_stall = ($urandom_range(0, 3) == 0);
                    end
                    2: begin
                        out_stall = ($urandom_range(0, 3) != 0);
                    end
                    default: begin
                        out_stall = ~out_stall;
                    end
                endcase
            end
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic ce);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = steady_input ? 0 : $urandom_range(0, 6);
            if (!steady_input && $urandom_range(0, 15) == 0) begin
                gap = $urandom_range(20, 40);
            end
            if (gap > 0) begin
                @(negedge clk);
                in_valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        in_valid = 1'b1;
        in_item.data_byte = b;
        in_item.chunk_end = ce;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        burst_left--;
        items_sent++;
    endtask

    task automatic send_message(input int p, input logic [31:0] len);
        for (int i = 0; i < p; i++) begin
            push_byte(len[8*i +: 8], 1'($urandom_range(0, 1)));
        end
        for (int i = 0; i < len; i++) begin
            push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic drain_input();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_prefix_size(input logic [lpd_pkg::PREFIX_W-1:0] size);
        drain_input();
        cfg_valid = 1'b1;
        cfg_data = size;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    initial begin
        logic [lpd_pkg::PREFIX_W-1:0] phase_sizes[12];
        int                           eff;
        int                           start_items;
        int                           r;
        logic [31:0]                  len;
        phase_sizes = '{3'd1, 3'd2, 3'd3, 3'd4, lpd_pkg::PREFIX_PASSTHROUGH, 3'd5, 3'd7,
                        lpd_pkg::PREFIX_PASSTHROUGH, 3'd6, 3'd2, 3'd4, 3'd1};

        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h5A, 1'b0);
        push_byte(8'hA5, 1'b1);
        write_prefix_size(lpd_pkg::PREFIX_PASSTHROUGH);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h3C, 1'b1);
        write_prefix_size(3'd7);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b1);

        foreach (phase_sizes[ph]) begin
            write_prefix_size(phase_sizes[ph]);
            eff = (phase_sizes[ph] > lpd_pkg::MAX_PREFIX_BYTES) ?
                  lpd_pkg::MAX_PREFIX_BYTES : phase_sizes[ph];
            steady_input = (ph % 4 == 3);
            if (ph == 1 || ph == 7) begin
                hold_req = 1'b1;
            end
            start_items = items_sent;
            if (ph == 9) begin
                send_message(eff, 32'd256 + 32'($urandom_range(0, 15)));
            end
            while (items_sent - start_items < PHASE_ITEMS) begin
                if (eff == 0) begin
                    push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 5) == 0));
                end else begin
                    r = $urandom_range(0, 9);
                    if (r == 0) begin
                        len = 32'd0;
                    end else if (r < 8) begin
                        len = 32'($urandom_range(1, 8));
                    end else begin
                        len = 32'($urandom_range(9, 40));
                    end
                    send_message(eff, len);
                end
            end
            if ($urandom_range(0, 2) == 0) begin
                repeat ($urandom_range(1, 6)) begin
                    push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                end
            end
        end

        drain_input();
        repeat (10) @(negedge clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/lpd_pkg.sv
rtl/lpd_framer.sv
rtl/length_prefix_deframer_unit.sv
tb/sv/length_prefix_deframer_checker.sv
tb/sv/length_prefix_deframer_unit_tb.sv
